// ----- hw/rtl/tlgr_pkg.sv -----
// Shared types, constants and glyph tables of the text line glyph renderer.
`timescale 1ns / 1ps

package tlgr_pkg;

	// Default width of the line in columns.
	localparam int LINE_PIXELS_DEFAULT = 64;

	// Width of the column position.
	localparam int POS_W = 7;
	// Width of a position with one spare bit, wide enough to hold the line width.
	localparam int STOP_W = 8;
	// Width of the column index on the result port.
	localparam int IDX_W = 6;
	// Width of a pixel column.
	localparam int BITS_W = 8;
	// Width of a character code.
	localparam int CODE_W = 8;
	// Width of a glyph row number.
	localparam int ROW_W = 5;

	localparam int GLYPH_COLS = 5;
	localparam int CELL_COLS = 6;

	// Depth of the command queue between the front and back parts.
	localparam int CMD_DEPTH = 2;

	// One unit of work for the back part: a glyph cell or a padding run.
	typedef struct packed {
		logic                 is_pad;
		logic [ROW_W-1:0]     row;
		logic [POS_W-1:0]     start;
	} cmd_t;

	// Maps a character code onto its glyph row; unknown codes take the blank row.
	function automatic logic [ROW_W-1:0] glyph_row(input logic [CODE_W-1:0] code);
		logic [ROW_W-1:0] r;
		case (code)
			8'h20: r = 5'd0;
			8'h2D: r = 5'd1;
			8'h3A: r = 5'd2;
			8'h30: r = 5'd3;
			8'h31: r = 5'd4;
			8'h32: r = 5'd5;
			8'h33: r = 5'd6;
			8'h34: r = 5'd7;
			8'h35: r = 5'd8;
			8'h36: r = 5'd9;
			8'h37: r = 5'd10;
			8'h38: r = 5'd11;
			8'h39: r = 5'd12;
			8'h41: r = 5'd13;
			8'h42: r = 5'd14;
			8'h43: r = 5'd15;
			8'h44: r = 5'd16;
			8'h45: r = 5'd17;
			8'h46: r = 5'd18;
			8'h47: r = 5'd19;
			8'h49: r = 5'd20;
			8'h4C: r = 5'd21;
			8'h4E: r = 5'd22;
			8'h4F: r = 5'd23;
			8'h52: r = 5'd24;
			8'h53: r = 5'd25;
			8'h54: r = 5'd26;
			8'h55: r = 5'd27;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Returns one column of a glyph; the five columns of a row run left to right.
	function automatic logic [BITS_W-1:0] glyph_col(input logic [ROW_W-1:0] row,
			input logic [2:0] col);
		logic [BITS_W*GLYPH_COLS-1:0] g;
		logic [BITS_W-1:0]            b;
		case (row)
			5'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			5'd1:  g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
			5'd2:  g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
			5'd3:  g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			5'd4:  g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			5'd5:  g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			5'd6:  g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			5'd7:  g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			5'd8:  g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			5'd9:  g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			5'd10: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			5'd11: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			5'd12: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			5'd13: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
			5'd14: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
			5'd15: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
			5'd16: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
			5'd17: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			5'd18: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
			5'd19: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
			5'd20: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
			5'd21: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			5'd22: g = {8'h7F, 8'h02, 8'h0C, 8'h10, 8'h7F};
			5'd23: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			5'd24: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			5'd25: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			5'd26: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
			5'd27: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
			default: g = '0;
		endcase
		case (col)
			3'd0: b = g[39:32];
			3'd1: b = g[31:24];
			3'd2: b = g[23:16];
			3'd3: b = g[15:8];
			3'd4: b = g[7:0];
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ----- hw/rtl/tlgr_front.sv -----
// Front part: accepts items, tracks the column position and issues commands.
`timescale 1ns / 1ps

module tlgr_front #(
	parameter int LINE_PIXELS = tlgr_pkg::LINE_PIXELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [tlgr_pkg::CODE_W-1:0]     text_char,
	input  logic                            line_end,
	input  logic                            q_full,
	output logic                            full,
	output logic                            cmd_wr,
	output tlgr_pkg::cmd_t                  cmd
);

	localparam int PW = tlgr_pkg::POS_W;
	localparam int SW = tlgr_pkg::STOP_W;
	localparam logic [SW-1:0] LINE_W = SW'(LINE_PIXELS);
	localparam logic [SW-1:0] CELL_W = SW'(tlgr_pkg::CELL_COLS);
	localparam logic [PW-1:0] CELL_P = PW'(tlgr_pkg::CELL_COLS);

	logic [PW-1:0] pos_q;
	logic [SW-1:0] pos_ext;
	logic          accept;
	logic          fits;
	logic          pad_needed;

	assign full       = q_full;
	assign accept     = push && !q_full;
	assign pos_ext    = {1'b0, pos_q};
	assign fits       = (pos_ext + CELL_W) <= LINE_W;
	assign pad_needed = pos_ext < LINE_W;

	assign cmd_wr     = accept && (line_end ? pad_needed : fits);
	assign cmd.is_pad = line_end;
	assign cmd.row    = tlgr_pkg::glyph_row(text_char);
	assign cmd.start  = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				pos_q <= '0;
			end else if (fits) begin
				pos_q <= pos_q + CELL_P;
			end
		end
	end

endmodule

// ----- hw/rtl/tlgr_cmd_queue.sv -----
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module tlgr_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tlgr_pkg::cmd_t wr_data,
	input  logic           rd_en,
	output logic           full,
	output logic           head_valid,
	output tlgr_pkg::cmd_t head
);

	localparam int DEPTH = tlgr_pkg::CMD_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	tlgr_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full       = count_q == CNT_FULL;
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = wr_en && !full;
	assign do_rd      = rd_en && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/tlgr_back.sv -----
// Back part: walks each command one column per cycle into the result register, stalling while the result is not popped.
`timescale 1ns / 1ps

module tlgr_back #(
	parameter int LINE_PIXELS = tlgr_pkg::LINE_PIXELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  tlgr_pkg::cmd_t                  head,
	output logic                            cmd_rd,
	output logic                            empty,
	input  logic                            pop,
	output logic [tlgr_pkg::BITS_W-1:0]     column_bits,
	output logic [tlgr_pkg::IDX_W-1:0]      column_index,
	output logic                            last
);

	localparam int PW = tlgr_pkg::POS_W;
	localparam int SW = tlgr_pkg::STOP_W;
	localparam int IW = tlgr_pkg::IDX_W;
	localparam logic [SW-1:0] LINE_W   = SW'(LINE_PIXELS);
	localparam logic [SW-1:0] CELL_W   = SW'(tlgr_pkg::CELL_COLS);
	localparam logic [PW-1:0] GLYPH_P  = PW'(tlgr_pkg::GLYPH_COLS);
	localparam logic [IW-1:0] LAST_IDX = IW'(LINE_PIXELS - 1);

	logic [PW-1:0]                off_q;
	logic [PW-1:0]                cur;
	logic [SW-1:0]                stop;
	logic                         final_col;
	logic                         emit;
	logic [tlgr_pkg::BITS_W-1:0]  bits_next;

	logic                         out_valid_q;
	logic [tlgr_pkg::BITS_W-1:0]  bits_q;
	logic [IW-1:0]                index_q;
	logic                         last_q;

	assign cur       = head.start + off_q;
	assign stop      = head.is_pad ? LINE_W : ({1'b0, head.start} + CELL_W);
	assign final_col = ({1'b0, cur} + 1'b1) == stop;
	assign emit      = head_valid && (!out_valid_q || pop);
	assign cmd_rd    = emit && final_col;

	always_comb begin
		if (!head.is_pad && off_q < GLYPH_P) begin
			bits_next = tlgr_pkg::glyph_col(head.row, off_q[2:0]);
		end else begin
			bits_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				off_q <= final_col ? '0 : off_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bits_q  <= bits_next;
			index_q <= cur[IW-1:0];
			last_q  <= head.is_pad && final_col;
		end
	end

	assign empty        = !out_valid_q;
	assign column_bits  = bits_q;
	assign column_index = index_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	// A closing column is always blank padding.
	a_last_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (bits_q == '0))
		else $error("last column carries pixels");

	// The closing column sits at the right-hand edge of the line.
	a_last_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (index_q == LAST_IDX))
		else $error("last column is not at the line edge");

	// The walk over a command never runs past its end.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, cur} < stop))
		else $error("column walk overran its command");
`endif

endmodule

// ----- hw/rtl/text_line_glyph_renderer_core.sv -----
// Top level of the text line glyph renderer: front part, command queue and back part.
`timescale 1ns / 1ps

// Renders one display line of text as vertical pixel columns, bit 0 being the top
// row. Each input transaction carries a character code and an end-of-line flag. A
// character that still fits in the line yields six result transactions (five glyph
// columns from a 5x7 font, then one blank column); one that does not fit is dropped
// and yields none. Codes outside the font render blank, like a space. An end-of-line
// transaction pads the rest of the line with blank columns, flags the final one with
// last, and restarts the line at column zero; if the line is already exactly full it
// yields nothing. Throughput is set by the column generator in the back part, which
// produces one column per cycle while the receiver keeps popping; a dropped character
// or an empty end-of-line is handled in the front part only. A two-entry command
// queue lets the front part take the next transaction while the back part is still
// working, and the first column of a transaction passes through the command queue
// and then the result register on its way to the result ports.
// column_index is the column position taken modulo 64.

module text_line_glyph_renderer_core #(
	parameter int LINE_PIXELS = tlgr_pkg::LINE_PIXELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [tlgr_pkg::CODE_W-1:0]     text_char,
	input  logic                            line_end,
	output logic                            empty,
	input  logic                            pop,
	output logic [tlgr_pkg::BITS_W-1:0]     column_bits,
	output logic [tlgr_pkg::IDX_W-1:0]      column_index,
	output logic                            last
);

	// Commands from the front part; each is a glyph cell or a padding run.
	tlgr_pkg::cmd_t cmd_in;
	tlgr_pkg::cmd_t cmd_head;
	logic           cmd_wr;
	logic           cmd_rd;
	logic           q_full;
	logic           head_valid;

	// The front part classifies each transaction and keeps the column position,
	// so the position is always up to date however far behind the back part is.
	tlgr_front #(
		.LINE_PIXELS (LINE_PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_char (text_char),
		.line_end  (line_end),
		.q_full    (q_full),
		.full      (full),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd_in)
	);

	tlgr_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cmd_wr),
		.wr_data    (cmd_in),
		.rd_en      (cmd_rd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (cmd_head)
	);

	// The back part works on the command at the head of the queue and retires it
	// as its final column enters the result register.
	tlgr_back #(
		.LINE_PIXELS (LINE_PIXELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (cmd_head),
		.cmd_rd       (cmd_rd),
		.empty        (empty),
		.pop          (pop),
		.column_bits  (column_bits),
		.column_index (column_index),
		.last         (last)
	);

endmodule

// ----- dv/text_line_glyph_renderer_core_test.sv -----
// Self-checking testbench for the text line glyph renderer core with a column scoreboard.
`timescale 1ns / 1ps

module text_line_glyph_renderer_core_test;

	localparam int LINE_PIXELS_DEFAULT = tlgr_pkg::LINE_PIXELS_DEFAULT;
	localparam int BITS_W              = tlgr_pkg::BITS_W;
	localparam int IDX_W               = tlgr_pkg::IDX_W;
	localparam int CODE_W              = tlgr_pkg::CODE_W;
	localparam int GLYPH_COLS          = tlgr_pkg::GLYPH_COLS;
	localparam int CELL_COLS           = tlgr_pkg::CELL_COLS;

	localparam int LINE = LINE_PIXELS_DEFAULT;
	// Cycles without any accepted transaction, on either side, before the run is abandoned.
	localparam int STALL_LIMIT = 3000;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int HOLD_OFF_CYCLES = 300;

	// One rendered pixel column as it appears on the result ports.
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [IDX_W-1:0]  index;
		logic              last;
	} column_t;

	// Keeps its own column position, renders each accepted transaction into the
	// columns it should produce and compares them with what the block delivers.
	class column_scoreboard;
		int        line_width;
		int        position;
		column_t   expected_columns[$];
		int        mismatches;
		int        items_seen;
		int        lines_seen;
		int        columns_checked;

		function new(int width);
			line_width      = width;
			position        = 0;
			mismatches      = 0;
			items_seen      = 0;
			lines_seen      = 0;
			columns_checked = 0;
		endfunction

		// The five columns of a character, left column in the top byte.
		function logic [BITS_W*GLYPH_COLS-1:0] glyph_bitmap(logic [CODE_W-1:0] code);
			case (code)
				8'h2D: return 40'h08_08_08_08_08;
				8'h3A: return 40'h00_36_36_00_00;
				8'h30: return 40'h3E_51_49_45_3E;
				8'h31: return 40'h00_42_7F_40_00;
				8'h32: return 40'h42_61_51_49_46;
				8'h33: return 40'h21_41_45_4B_31;
				8'h34: return 40'h18_14_12_7F_10;
				8'h35: return 40'h27_45_45_45_39;
				8'h36: return 40'h3C_4A_49_49_30;
				8'h37: return 40'h01_71_09_05_03;
				8'h38: return 40'h36_49_49_49_36;
				8'h39: return 40'h06_49_49_29_1E;
				8'h41: return 40'h7E_11_11_11_7E;
				8'h42: return 40'h7F_49_49_49_36;
				8'h43: return 40'h3E_41_41_41_22;
				8'h44: return 40'h7F_41_41_22_1C;
				8'h45: return 40'h7F_49_49_49_41;
				8'h46: return 40'h7F_09_09_09_01;
				8'h47: return 40'h3E_41_49_49_7A;
				8'h49: return 40'h00_41_7F_41_00;
				8'h4C: return 40'h7F_40_40_40_40;
				8'h4E: return 40'h7F_02_0C_10_7F;
				8'h4F: return 40'h3E_41_41_41_3E;
				8'h52: return 40'h7F_09_19_29_46;
				8'h53: return 40'h46_49_49_49_31;
				8'h54: return 40'h01_01_7F_01_01;
				8'h55: return 40'h3F_40_40_40_3F;
				// Space and every code outside the font are blank.
				default: return '0;
			endcase
		endfunction

		// Works out the columns one accepted transaction causes and queues them.
		function void render_item(logic [CODE_W-1:0] code, logic end_of_line);
			logic [BITS_W*GLYPH_COLS-1:0] bitmap;
			column_t                      col;
			items_seen++;
			if (end_of_line) begin
				lines_seen++;
				// Pad from the current position to the end of the line; nothing if full.
				for (int c = position; c < line_width; c++) begin
					col.bits  = '0;
					col.index = IDX_W'(c);
					col.last  = (c + 1 == line_width);
					expected_columns.push_back(col);
				end
				position = 0;
			end else if (position + CELL_COLS <= line_width) begin
				bitmap = glyph_bitmap(code);
				for (int c = 0; c < CELL_COLS; c++) begin
					col.bits  = (c < GLYPH_COLS) ?
						bitmap[BITS_W*(GLYPH_COLS-c)-1 -: BITS_W] : '0;
					col.index = IDX_W'(position + c);
					col.last  = 1'b0;
					expected_columns.push_back(col);
				end
				position = (position + CELL_COLS) & 7'h7F;
			end
			// A character that does not fit is dropped and leaves the position alone.
		endfunction

		// Compares one delivered column with the oldest outstanding expectation.
		function void check_column(column_t got);
			column_t want;
			if (expected_columns.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected column: bits=%02h index=%0d last=%0b",
						got.bits, got.index, got.last);
				return;
			end
			want = expected_columns.pop_front();
			columns_checked++;
			if (got.bits !== want.bits || got.index !== want.index ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("column mismatch: expected bits=%02h index=%0d last=%0b,%s",
						want.bits, want.index, want.last,
						$sformatf(" got bits=%02h index=%0d last=%0b",
							got.bits, got.index, got.last));
			end
		endfunction

		function int pending();
			return expected_columns.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [CODE_W-1:0] text_char;
	logic              line_end;
	logic              empty;
	logic              pop;
	logic [BITS_W-1:0] column_bits;
	logic [IDX_W-1:0]  column_index;
	logic              last;

	column_scoreboard sb;

	// Idling controls, in percent of cycles, changed from phase to phase.
	int send_gap_pct;
	int recv_stall_pct;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_request;
	int quiet_cycles;

	// Character codes the font knows, used to keep most random text printable.
	logic [CODE_W-1:0] known_codes [28] = '{
		8'h20, 8'h2D, 8'h3A, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
		8'h49, 8'h4C, 8'h4E, 8'h4F, 8'h52, 8'h53, 8'h54, 8'h55
	};

	text_line_glyph_renderer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.text_char    (text_char),
		.line_end     (line_end),
		.empty        (empty),
		.pop          (pop),
		.column_bits  (column_bits),
		.column_index (column_index),
		.last         (last)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		text_char = '0;
		line_end  = 1'b0;
	end

	// Offers one transaction, with random idle cycles in front of it, and returns at
	// the edge that accepted it. push stays high for a following back-to-back call.
	task automatic send_text(logic [CODE_W-1:0] code, logic end_of_line);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		text_char <= code;
		line_end  <= end_of_line;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.render_item(code, end_of_line);
	endtask

	// Mostly whole lines of random length with mostly printable text, the rest loose
	// transactions of any content, so that drops and short pads all turn up.
	task automatic send_random(int count);
		int sent;
		int chars;
		logic [CODE_W-1:0] code;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 80) begin
				chars = $urandom_range(0, 12);
				for (int k = 0; k < chars; k++) begin
					code = ($urandom_range(0, 3) != 0) ? known_codes[$urandom_range(0, 27)]
						: CODE_W'($urandom_range(0, 255));
					send_text(code, 1'b0);
				end
				send_text(CODE_W'($urandom_range(0, 255)), 1'b1);
				sent += chars + 1;
			end else begin
				send_text(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// Receiver: checks each accepted column, then decides whether to pop at the next
	// edge. A hold-off request is served here, counted in this process's own cycles.
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_column('{column_bits, column_index, last});
			if (hold_request) begin
				hold_left    = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: a run that stops moving on both sides is a failure.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		sb             = new(LINE);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		quiet_cycles   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: an end of line on an empty line pads the whole width, then a line
		// filled past its capacity with the code extremes, blanks, unknown codes and
		// glyphs, so that the last characters are dropped. The closing end of line
		// carries an all-ones code that must be ignored.
		send_text(8'h00, 1'b1);
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		send_text(8'h20, 1'b0);
		send_text(8'h2D, 1'b0);
		send_text(8'h3A, 1'b0);
		send_text(8'h30, 1'b0);
		send_text(8'h39, 1'b0);
		send_text(8'h41, 1'b0);
		send_text(8'h55, 1'b0);
		send_text(8'h7F, 1'b0);
		send_text(8'h45, 1'b0);
		send_text(8'h53, 1'b0);
		send_text(8'hFF, 1'b1);
		send_text(8'h47, 1'b0);
		send_text(8'h52, 1'b0);
		send_text(8'h80, 1'b1);
		send_text(8'h00, 1'b1);

		// Random phases with different idling on each side.
		send_random(80);
		send_gap_pct = 63;
		send_random(70);
		send_gap_pct   = 0;
		recv_stall_pct = 63;
		send_random(70);
		send_gap_pct   = 25;
		recv_stall_pct = 25;
		send_random(70);

		// Back-pressure: the receiver holds off while the sender keeps offering.
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b1;
		send_random(30);
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Rendered %0d text transactions in %0d lines into %0d checked columns,",
			sb.items_seen, sb.lines_seen, sb.columns_checked);
		$display("with idle sender, stalled receiver and a long hold-off; %0d mismatches.",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
